/* src/bounded_deque_with_search_core_defines.svh */
// Assertion macros shared by the deque core.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define BDQS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define BDQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bdqs_pkg.sv */
`timescale 1ns / 1ps
package bdqs_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_REMOVE     = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Control strobes from the sequencer to the ring store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic head_dec;
    logic head_inc;
  } ring_ctl_t;

endpackage

/* src/bdqs_in_if.sv */
`timescale 1ns / 1ps
interface bdqs_in_if import bdqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

/* src/bdqs_out_if.sv */
`timescale 1ns / 1ps
interface bdqs_out_if import bdqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [POS_W-1:0]         position;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, output data_out, output position, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input data_out, input position, input status,
                  input entry_count, output ready);
endinterface

/* src/bdqs_ring.sv */
`timescale 1ns / 1ps
module bdqs_ring import bdqs_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ring_ctl_t         ctl,
  input  logic [AW-1:0]     rd_idx,
  input  logic [AW-1:0]     wr_idx,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     head_m1, head_p1;
  logic [AW-1:0]     rd_addr, wr_addr;

  // Map a position counted from the front to a slot of the ring
  function automatic logic [AW-1:0] to_slot(input logic [AW-1:0] h,
                                            input logic [AW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign head_m1 = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_p1 = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign rd_addr = to_slot(head_r, rd_idx);
  assign wr_addr = ctl.head_dec ? head_m1 : to_slot(head_r, wr_idx);

  // Move the front pointer on push front or pop front
  always_comb begin
    head_nxt = head_r;
    if (ctl.head_dec) begin
      head_nxt = head_m1;
    end else if (ctl.head_inc) begin
      head_nxt = head_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  // Write one slot and read one slot each cycle, when enabled
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/bounded_deque_with_search_core.sv */
`timescale 1ns / 1ps
// Channel | Dir | Payload                                       | Moves on
// in_ch   | in  | opcode, operand_value                         | valid & ready
// out_ch  | out | data_out, position, status, entry_count       | valid & ready
//
// A push goes straight to the result stage and a pop passes through S_POP; find
// scans in S_CMP, and remove then moves each entry behind the match in S_SHIFT.
// The scan and the close-up both run through the ring store's single read and
// write port, one entry per cycle. in_ch.ready is high only while idle.
// rst_n is synchronous; it empties the store. A waiting result holds in the
// output register while the next item is accepted; a second result waits.
module bounded_deque_with_search_core import bdqs_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  bdqs_in_if.sink   in_ch,
  bdqs_out_if.source out_ch
);

`include "bounded_deque_with_search_core_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_CMP   = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  status_t           status_r, status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  ring_ctl_t         ctl;
  logic [AW-1:0]     rd_idx, wr_idx;
  logic [DATA_W-1:0] wr_data, rd_data;

  logic              in_fire;
  logic              full, empty;
  logic              push_ok, scan_busy;
  logic [CW-1:0]     idx_p1, idx_p2, count_m1;
  logic [AW+POS_W-1:0]   pos_wide;
  logic [CW+COUNT_W-1:0] count_wide;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign idx_p1   = CW'(idx_r) + 1'b1;
  assign idx_p2   = CW'(idx_r) + 2'd2;
  assign count_m1 = count_r - 1'b1;
  assign pos_wide   = (AW+POS_W)'(pos_r);
  assign count_wide = (CW+COUNT_W)'(count_r);

  bdqs_ring #(.DEPTH(DEPTH)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_idx  (rd_idx),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Sequence one item through the ring store
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    data_nxt   = data_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    ctl        = '0;
    rd_idx     = '0;
    wr_idx     = '0;
    wr_data    = val_r;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    out_pos_nxt    = out_pos_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = op_t'(in_ch.opcode);
          val_nxt    = in_ch.operand_value;
          data_nxt   = '0;
          pos_nxt    = '0;
          status_nxt = ST_OK;
          idx_nxt    = '0;
          state_nxt  = S_DONE;
          case (op_t'(in_ch.opcode))
            OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.wr_en    = 1'b1;
                ctl.head_dec = 1'b1;
                wr_data      = in_ch.operand_value;
                count_nxt    = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.wr_en = 1'b1;
                wr_idx    = count_r[AW-1:0];
                wr_data   = in_ch.operand_value;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                ctl.rd_en    = 1'b1;
                ctl.head_inc = 1'b1;
                count_nxt    = count_m1;
                state_nxt    = S_POP;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                ctl.rd_en = 1'b1;
                rd_idx    = count_m1[AW-1:0];
                count_nxt = count_m1;
                state_nxt = S_POP;
              end
            end
            OP_FIND: begin
              if (empty) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                ctl.rd_en = 1'b1;
                state_nxt = S_CMP;
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                ctl.rd_en = 1'b1;
                state_nxt = S_CMP;
              end
            end
            default: ;
          endcase
        end
      end

      // Take the popped word from the store
      S_POP: begin
        data_nxt  = rd_data;
        state_nxt = S_DONE;
      end

      // Compare one entry per cycle while fetching the next
      S_CMP: begin
        if (rd_data == val_r) begin
          if (op_r == OP_FIND) begin
            pos_nxt   = idx_r;
            state_nxt = S_DONE;
          end else begin
            data_nxt = rd_data;
            if (idx_p1 < count_r) begin
              ctl.rd_en = 1'b1;
              rd_idx    = idx_p1[AW-1:0];
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = count_m1;
              state_nxt = S_DONE;
            end
          end
        end else if (idx_p1 == count_r) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          ctl.rd_en = 1'b1;
          rd_idx    = idx_p1[AW-1:0];
          idx_nxt   = idx_p1[AW-1:0];
        end
      end

      // Close the gap: move each later entry one place toward the front
      S_SHIFT: begin
        ctl.wr_en = 1'b1;
        wr_idx    = idx_r;
        wr_data   = rd_data;
        idx_nxt   = idx_p1[AW-1:0];
        if (idx_p2 < count_r) begin
          ctl.rd_en = 1'b1;
          rd_idx    = idx_p2[AW-1:0];
        end else begin
          count_nxt = count_m1;
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = data_r;
          out_pos_nxt    = pos_wide[POS_W-1:0];
          out_status_nxt = status_r;
          out_count_nxt  = count_wide[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    data_r       <= data_nxt;
    pos_r        <= pos_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_pos_r    <= out_pos_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;

  // Qualifiers for the checks below
  assign push_ok   = in_fire && !full &&
                     (in_ch.opcode == OP_PUSH_FRONT || in_ch.opcode == OP_PUSH_BACK);
  assign scan_busy = (state_r == S_CMP) || (state_r == S_SHIFT);

  `BDQS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count above depth")
  `BDQS_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ch.ready, "ready right after accept")
  `BDQS_ASSERT_NEXT(a_push_grows, push_ok, count_r == $past(count_r) + 1'b1, "push lost an entry")
  `BDQS_ASSERT_NOW(a_scan_nonempty, scan_busy, count_r != '0, "scan over an empty store")
  `BDQS_ASSERT_NOW(a_shift_remove, state_r == S_SHIFT, op_r == OP_REMOVE, "close-up outside remove")

endmodule

/* tb/sv/bounded_deque_with_search_core_tb.sv */
`timescale 1ns / 1ps
module bounded_deque_with_search_core_tb;
  import bdqs_pkg::*;

  localparam int DEPTH           = 16;
  localparam int RANDOM_ITEMS    = 1000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 60;
  localparam int CYCLE_LIMIT     = 400_000;

  // Opcodes outside the enum; the block must treat them as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         pos;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
  } result_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    bit                       fixed_result;
    result_t                  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bdqs_in_if  in_ch ();
  bdqs_out_if out_ch ();

  bounded_deque_with_search_core #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the deque contents, front at index 0
  logic signed [DATA_W-1:0] model_words[$];
  stim_row_t                queued_items[$];
  result_t                  pending_results[$];
  stim_row_t                directed_rows[$];

  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  int          burst_left     = 8;

  bit          hold_off_req  = 1'b0;
  int          hold_off_left = 0;
  int          pace_left     = 0;
  logic [7:0]  stall_pat     = 8'hFF;

  op_t op_order [6] = '{OP_PUSH_BACK, OP_PUSH_FRONT, OP_POP_FRONT, OP_POP_BACK,
                        OP_FIND, OP_REMOVE};
  // Cumulative percent cuts over op_order: fill, drain, mixed
  int unsigned op_cuts [3][5] = '{'{40, 65, 75, 80, 90},
                                  '{12, 22, 42, 60, 75},
                                  '{22, 40, 52, 64, 82}};
  logic signed [DATA_W-1:0] value_pool [8] = '{WORD_MIN, WORD_MAX, 32'sd0, -32'sd1,
                                               32'sd1, 32'sd2, 32'sd3, 32'sh5555_5555};

  // Apply one operation to the mirror and return the result it produces
  function automatic result_t apply_deque_op(logic [OP_W-1:0] op,
                                             logic signed [DATA_W-1:0] v);
    result_t r;
    int      hit;
    r.data   = '0;
    r.pos    = '0;
    r.status = ST_OK;
    hit      = -1;
    foreach (model_words[i])
      if (hit < 0 && model_words[i] == v) hit = i;
    case (op)
      OP_PUSH_FRONT: begin
        if (model_words.size() >= DEPTH) r.status = ST_FULL;
        else model_words.push_front(v);
      end
      OP_PUSH_BACK: begin
        if (model_words.size() >= DEPTH) r.status = ST_FULL;
        else model_words.push_back(v);
      end
      OP_POP_FRONT: begin
        if (model_words.size() == 0) r.status = ST_EMPTY;
        else r.data = model_words.pop_front();
      end
      OP_POP_BACK: begin
        if (model_words.size() == 0) r.status = ST_EMPTY;
        else r.data = model_words.pop_back();
      end
      OP_FIND: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.pos = POS_W'(hit);
      end
      OP_REMOVE: begin
        if (model_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.data = model_words[hit];
          model_words.delete(hit);
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(model_words.size());
    return r;
  endfunction

  function automatic stim_row_t make_row(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v,
                                         bit fixed_result = 1'b0,
                                         logic signed [DATA_W-1:0] data = '0,
                                         logic [POS_W-1:0] pos = '0,
                                         status_t st = ST_OK,
                                         logic [COUNT_W-1:0] cnt = '0);
    stim_row_t row;
    row.op           = op;
    row.value        = v;
    row.fixed_result = fixed_result;
    row.want.data    = data;
    row.want.pos     = pos;
    row.want.status  = st;
    row.want.count   = cnt;
    return row;
  endfunction

  // Distinct fill words, with the all-ones and zero words early on
  function automatic logic signed [DATA_W-1:0] fill_word(int i);
    if (i == 1) return -32'sd1;
    if (i == 2) return 32'sd0;
    return 32'sh1000_0001 * i;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(int lean);
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 2) return $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
    for (int k = 0; k < 5; k++)
      if (w < op_cuts[lean][k]) return op_order[k];
    return op_order[5];
  endfunction

  // Favor words already held so finds and removes hit
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35 && model_words.size() > 0)
      return model_words[$urandom_range(0, model_words.size() - 1)];
    if (r < 65) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Offer one item and hold it until the block takes it
  task automatic send_item(stim_row_t row);
    queued_items.push_back(row);
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= row.op;
    in_ch.operand_value <= row.value;
    do @(posedge clk); while (!in_ch.ready);
    items_accepted++;
  endtask

  // Drop valid for a short gap once the current burst runs out
  task automatic idle_after_item();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
    end
  endtask

  // Hold off the sender until every accepted item has its result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_seen < items_accepted) @(posedge clk);
  endtask

  function automatic void build_directed();
    directed_rows.push_back(make_row(OP_POP_FRONT, 32'sd9, 1, '0, '0, ST_EMPTY, 5'd0));
    directed_rows.push_back(make_row(OP_POP_BACK, 32'sd9, 1, '0, '0, ST_EMPTY, 5'd0));
    directed_rows.push_back(make_row(OP_REMOVE, 32'sd7, 1, '0, '0, ST_EMPTY, 5'd0));
    directed_rows.push_back(make_row(OP_FIND, 32'sd7, 1, '0, '0, ST_NOTFOUND, 5'd0));
    directed_rows.push_back(make_row(OP_SPARE_6, 32'sd123, 1, '0, '0, ST_OK, 5'd0));
    directed_rows.push_back(make_row(OP_PUSH_BACK, WORD_MAX, 1, '0, '0, ST_OK, 5'd1));
    // Removing the only entry must leave an empty store
    directed_rows.push_back(make_row(OP_REMOVE, WORD_MAX, 1, WORD_MAX, '0, ST_OK, 5'd0));
    directed_rows.push_back(make_row(OP_PUSH_FRONT, WORD_MIN, 1, '0, '0, ST_OK, 5'd1));
    for (int i = 1; i < DEPTH; i++)
      directed_rows.push_back(make_row(OP_PUSH_BACK, fill_word(i)));
    // Store is full: pushes at both ends are dropped
    directed_rows.push_back(make_row(OP_PUSH_FRONT, 32'sd5, 1, '0, '0, ST_FULL, 5'd16));
    directed_rows.push_back(make_row(OP_PUSH_BACK, 32'sd5, 1, '0, '0, ST_FULL, 5'd16));
    directed_rows.push_back(make_row(OP_FIND, fill_word(DEPTH - 1), 1, '0, 4'd15, ST_OK,
                                     5'd16));
    directed_rows.push_back(make_row(OP_REMOVE, fill_word(7)));
    directed_rows.push_back(make_row(OP_REMOVE, 32'sd5, 1, '0, '0, ST_NOTFOUND, 5'd15));
    directed_rows.push_back(make_row(OP_POP_FRONT, 32'sd0, 1, WORD_MIN, '0, ST_OK, 5'd14));
  endfunction

  // Track accepted items and check each result against the oldest expectation
  always @(posedge clk) begin : result_check
    stim_row_t row;
    result_t   want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        row  = queued_items.pop_front();
        want = apply_deque_op(row.op, row.value);
        if (row.fixed_result) want = row.want;
        pending_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (out_ch.data_out !== want.data)
            report_mismatch($sformatf("result %0d data_out: got %0d, expected %0d",
                                      results_seen, out_ch.data_out, want.data));
          if (out_ch.position !== want.pos)
            report_mismatch($sformatf("result %0d position: got %0d, expected %0d",
                                      results_seen, out_ch.position, want.pos));
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                      results_seen, out_ch.status, want.status));
          if (out_ch.entry_count !== want.count)
            report_mismatch($sformatf("result %0d entry_count: got %0d, expected %0d",
                                      results_seen, out_ch.entry_count, want.count));
        end
      end
    end
  end

  // Receiver pacing: rotating stall pattern, plus a long hold-off on request
  always @(posedge clk) begin : result_pacing
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req  = 1'b0;
      hold_off_left = HOLD_OFF_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace_left = $urandom_range(16, 96);
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      pace_left--;
      out_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int lean;
    lean                = 2;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = '0;
    in_ch.operand_value = '0;
    out_ch.ready        = 1'b0;
    rst_n               = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    build_directed();
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
      idle_after_item();
    end
    wait_drained();

    // Random sequences, leaning toward fill, drain or a mix per stretch
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) lean = $urandom_range(0, 2);
      if (n == 300) hold_off_req = 1'b1;
      send_item(make_row(pick_op(lean), pick_value()));
      if (n % 150 == 149) wait_drained();
      else idle_after_item();
    end

    // Drain and let any stray result show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
